@@ hdl/nrsi_pkg.sv @@
// Shared types, widths and mode codes for the nearest-resize source index block.
// Depends on nothing; every other file in hdl refers to it by scoped names.
package nrsi_pkg;

    // Field widths of the item channels
    localparam int POS_W   = 12;
    localparam int EXT_W   = 13;
    localparam int SRC_W   = 14;
    localparam int CLAMP_W = 12;

    // Arithmetic widths: 2*pos+1 times an extent, signed numerator, doubled extent
    localparam int OPA_W  = POS_W + 1;
    localparam int PROD_W = OPA_W + EXT_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DEN_W  = EXT_W + 1;

    // Quotient bits resolved by the divider; anything larger saturates anyway
    localparam int Q_W                 = SRC_W;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = Q_W / DIV_STEPS_PER_STAGE;
    localparam int IDX_W               = Q_W + 2;

    localparam int MAX_EXTENT_DEFAULT = 4096;

    // Configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    typedef enum logic {
        REG_COORD_MODE    = 1'b0,
        REG_ROUNDING_MODE = 1'b1
    } reg_index_t;

    // COORD_CENTRED_NZ is the centred rule that returns zero for a single-pixel output
    typedef enum logic [1:0] {
        COORD_CENTRED    = 2'd0,
        COORD_CORNER_FIT = 2'd1,
        COORD_ASYMMETRIC = 2'd2,
        COORD_CENTRED_NZ = 2'd3
    } coord_mode_t;

    typedef enum logic [1:0] {
        ROUND_TIE_DOWN = 2'd0,
        ROUND_TIE_UP   = 2'd1,
        ROUND_FLOOR    = 2'd2,
        ROUND_CEIL     = 2'd3
    } round_mode_t;

    typedef struct packed {
        logic [POS_W-1:0] out_pos;
        logic [EXT_W-1:0] out_extent;
        logic [EXT_W-1:0] in_extent;
    } req_item_t;

    typedef struct packed {
        logic signed [SRC_W-1:0] src_index;
        logic [CLAMP_W-1:0]      clamped_index;
    } rsp_item_t;

    // Non-negative dividend and divisor handed to the divider
    typedef struct packed {
        logic [PROD_W-1:0] n;
        logic [DEN_W-1:0]  den;
        logic              qneg;
        logic              zero;
        logic [EXT_W-1:0]  in_extent;
    } front_item_t;

    // One divider stage: partial remainder, unused dividend bits, quotient so far
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   nlow;
        logic [Q_W-1:0]   q;
        logic [DEN_W-1:0] den;
        logic             qneg;
        logic             ovf;
        logic             zero;
        logic [EXT_W-1:0] in_extent;
    } div_stage_t;

endpackage

@@ hdl/nrsi_front.sv @@
// Front end: selects the coordinate rule, multiplies, subtracts and folds a
// negative numerator into a non-negative dividend. Depends on nrsi_pkg.
module nrsi_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  nrsi_pkg::coord_mode_t    coord_mode,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  nrsi_pkg::req_item_t      in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output nrsi_pkg::front_item_t    out_item
);

    typedef struct packed {
        logic [nrsi_pkg::PROD_W-1:0] prod;
        logic [nrsi_pkg::EXT_W-1:0]  sub;
        logic [nrsi_pkg::DEN_W-1:0]  den;
        logic                        zero;
        logic [nrsi_pkg::EXT_W-1:0]  in_extent;
    } mul_stage_t;

    typedef struct packed {
        logic signed [nrsi_pkg::NUM_W-1:0] num;
        logic [nrsi_pkg::DEN_W-1:0]        den;
        logic                              zero;
        logic [nrsi_pkg::EXT_W-1:0]        in_extent;
    } num_stage_t;

    mul_stage_t            a_reg, a_next;
    num_stage_t            b_reg, b_next;
    nrsi_pkg::front_item_t c_reg, c_next;
    logic                  a_valid_reg, b_valid_reg, c_valid_reg;
    logic                  en_a, en_b, en_c;

    logic [nrsi_pkg::OPA_W-1:0] opa;
    logic [nrsi_pkg::EXT_W-1:0] opb;
    logic                       out_le1;
    logic                       out_eq0;
    logic signed [nrsi_pkg::NUM_W-1:0] num_fold;

    // Advance a stage when it is empty or the next one moves
    assign en_c     = ~c_valid_reg | out_ready;
    assign en_b     = ~b_valid_reg | en_c;
    assign en_a     = ~a_valid_reg | en_b;
    assign in_ready = en_a;

    // Pick multiplier operands, divisor and subtrahend for the coordinate rule
    always_comb
    begin
        out_eq0 = (in_item.out_extent == '0);
        out_le1 = (in_item.out_extent <= nrsi_pkg::EXT_W'(1));
        case (coord_mode)
            nrsi_pkg::COORD_CORNER_FIT:
            begin
                opa        = {1'b0, in_item.out_pos};
                opb        = in_item.in_extent - nrsi_pkg::EXT_W'(1);
                a_next.den = nrsi_pkg::DEN_W'(in_item.out_extent) - nrsi_pkg::DEN_W'(1);
                a_next.sub = '0;
            end
            nrsi_pkg::COORD_ASYMMETRIC:
            begin
                opa        = {1'b0, in_item.out_pos};
                opb        = in_item.in_extent;
                a_next.den = {1'b0, in_item.out_extent};
                a_next.sub = '0;
            end
            default:
            begin
                opa        = {in_item.out_pos, 1'b1};
                opb        = in_item.in_extent;
                a_next.den = {in_item.out_extent, 1'b0};
                a_next.sub = in_item.out_extent;
            end
        endcase
        // Empty input, zero divisor, or single-pixel output under the zeroing rule
        a_next.zero = (in_item.in_extent == '0)
                    | ((coord_mode == nrsi_pkg::COORD_CORNER_FIT) ? out_le1 : out_eq0)
                    | ((coord_mode == nrsi_pkg::COORD_CENTRED_NZ) & out_le1);
        a_next.prod      = nrsi_pkg::PROD_W'(opa) * nrsi_pkg::PROD_W'(opb);
        a_next.in_extent = in_item.in_extent;
    end

    // Form the signed numerator
    always_comb
    begin
        b_next.num       = $signed({1'b0, a_reg.prod})
                         - $signed({{(nrsi_pkg::NUM_W - nrsi_pkg::EXT_W){1'b0}}, a_reg.sub});
        b_next.den       = a_reg.den;
        b_next.zero      = a_reg.zero;
        b_next.in_extent = a_reg.in_extent;
    end

    // Fold a negative numerator: its floor is -1 with remainder num + den
    always_comb
    begin
        num_fold         = b_reg.num
                         + $signed({{(nrsi_pkg::NUM_W - nrsi_pkg::DEN_W){1'b0}}, b_reg.den});
        c_next.qneg      = b_reg.num[nrsi_pkg::NUM_W-1];
        c_next.n         = c_next.qneg ? num_fold[nrsi_pkg::PROD_W-1:0]
                                       : b_reg.num[nrsi_pkg::PROD_W-1:0];
        c_next.den       = b_reg.den;
        c_next.zero      = b_reg.zero;
        c_next.in_extent = b_reg.in_extent;
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                a_valid_reg <= in_valid;
            if (en_b)
                b_valid_reg <= a_valid_reg;
            if (en_c)
                c_valid_reg <= b_valid_reg;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en_a)
            a_reg <= a_next;
        if (en_b)
            b_reg <= b_next;
        if (en_c)
            c_reg <= c_next;
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_reg;

endmodule

@@ hdl/nrsi_div.sv @@
// Pipelined restoring divider: an overflow check stage, then a few quotient bits
// per stage until the quotient is complete. Depends on nrsi_pkg.
module nrsi_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  nrsi_pkg::front_item_t  in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output nrsi_pkg::div_stage_t   out_item
);

    localparam int LAST = nrsi_pkg::DIV_STAGES;

    nrsi_pkg::div_stage_t stage_reg  [LAST+1];
    nrsi_pkg::div_stage_t stage_next [LAST+1];
    logic [LAST:0]        valid_reg;
    logic [LAST:0]        valid_next;
    logic [LAST:0]        en;
    logic [nrsi_pkg::DEN_W-1:0] head;

    // Shift in dividend bits one at a time, subtracting the divisor where it fits
    function automatic nrsi_pkg::div_stage_t div_step(input nrsi_pkg::div_stage_t s);
        nrsi_pkg::div_stage_t o;
        logic [nrsi_pkg::DEN_W:0] t;
        o = s;
        for (int j = 0; j < nrsi_pkg::DIV_STEPS_PER_STAGE; j++)
        begin
            t      = {o.rem, o.nlow[nrsi_pkg::Q_W-1]};
            o.nlow = {o.nlow[nrsi_pkg::Q_W-2:0], 1'b0};
            if (t >= {1'b0, o.den})
            begin
                o.rem = nrsi_pkg::DEN_W'(t - {1'b0, o.den});
                o.q   = {o.q[nrsi_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = t[nrsi_pkg::DEN_W-1:0];
                o.q   = {o.q[nrsi_pkg::Q_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // Load the upper dividend bits; flag a quotient too wide for the result
    always_comb
    begin
        head = nrsi_pkg::DEN_W'(in_item.n[nrsi_pkg::PROD_W-1:nrsi_pkg::Q_W]);
        stage_next[0].rem       = head;
        stage_next[0].nlow      = in_item.n[nrsi_pkg::Q_W-1:0];
        stage_next[0].q         = '0;
        stage_next[0].den       = in_item.den;
        stage_next[0].qneg      = in_item.qneg;
        stage_next[0].ovf       = (head >= in_item.den);
        stage_next[0].zero      = in_item.zero;
        stage_next[0].in_extent = in_item.in_extent;
    end

    genvar k;
    generate
        for (k = 1; k <= LAST; k++)
        begin : g_step
            assign stage_next[k] = div_step(stage_reg[k-1]);
        end
        for (k = 0; k < LAST; k++)
        begin : g_en
            assign en[k] = ~valid_reg[k] | en[k+1];
        end
    endgenerate

    assign en[LAST] = ~valid_reg[LAST] | out_ready;
    assign in_ready = en[0];

    // Advance valid bits with their stages
    always_comb
    begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int i = 1; i <= LAST; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= LAST; i++)
        begin
            if (en[i])
                stage_reg[i] <= stage_next[i];
        end
    end

    assign out_valid = valid_reg[LAST];
    assign out_item  = stage_reg[LAST];

endmodule

@@ hdl/nrsi_back.sv @@
// Back end: applies the selected rounding mode, then saturates the raw index and
// clamps it into the input axis. Depends on nrsi_pkg.
module nrsi_back #(
    parameter int MAX_EXTENT = nrsi_pkg::MAX_EXTENT_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nrsi_pkg::round_mode_t rounding_mode,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  nrsi_pkg::div_stage_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output nrsi_pkg::rsp_item_t   out_item
);

    localparam int CAP_W = $clog2(MAX_EXTENT + 1);
    localparam int CMP_W = ((CAP_W > nrsi_pkg::IDX_W) ? CAP_W : nrsi_pkg::IDX_W) + 1;
    localparam logic signed [CMP_W-1:0] CAP       = CMP_W'(MAX_EXTENT);
    localparam logic signed [CMP_W-1:0] FIELD_MAX = CMP_W'(2 ** nrsi_pkg::CLAMP_W - 1);
    localparam logic signed [CMP_W-1:0] SRC_HI    = CMP_W'(2 ** (nrsi_pkg::SRC_W - 1) - 1);
    localparam logic signed [CMP_W-1:0] SRC_LO    = CMP_W'(-(2 ** (nrsi_pkg::SRC_W - 1)));

    typedef struct packed {
        logic signed [nrsi_pkg::IDX_W-1:0] idx;
        logic                              zero;
        logic [nrsi_pkg::EXT_W-1:0]        in_extent;
    } round_stage_t;

    round_stage_t        r_reg, r_next;
    nrsi_pkg::rsp_item_t o_reg, o_next;
    logic                r_valid_reg, o_valid_reg;
    logic                en_r, en_o;

    logic [nrsi_pkg::DEN_W:0]          twice_r;
    logic [nrsi_pkg::DEN_W:0]          den_x;
    logic                              up;
    logic signed [nrsi_pkg::IDX_W-1:0] q_sel;

    logic signed [CMP_W-1:0] idx_w, in_w, lim, hi, cl0, cl1, cl2, src_w;

    assign en_o     = ~o_valid_reg | out_ready;
    assign en_r     = ~r_valid_reg | en_o;
    assign in_ready = en_r;

    // Decide whether to step up from the floor
    always_comb
    begin
        twice_r = {in_item.rem, 1'b0};
        den_x   = {1'b0, in_item.den};
        case (rounding_mode)
            nrsi_pkg::ROUND_TIE_DOWN: up = (twice_r > den_x);
            nrsi_pkg::ROUND_TIE_UP:   up = (twice_r >= den_x);
            nrsi_pkg::ROUND_FLOOR:    up = 1'b0;
            nrsi_pkg::ROUND_CEIL:     up = (in_item.rem != '0);
            default:                  up = 1'b0;
        endcase
        if (in_item.qneg)
            q_sel = '1;
        else if (in_item.ovf)
            q_sel = $signed({2'b00, {nrsi_pkg::Q_W{1'b1}}});
        else
            q_sel = $signed({2'b00, in_item.q});
        r_next.idx       = q_sel + $signed({{(nrsi_pkg::IDX_W - 1){1'b0}}, up});
        r_next.zero      = in_item.zero;
        r_next.in_extent = in_item.in_extent;
    end

    // Saturate the raw index and clamp into the input axis
    always_comb
    begin
        idx_w = {{(CMP_W - nrsi_pkg::IDX_W){r_reg.idx[nrsi_pkg::IDX_W-1]}}, r_reg.idx};
        in_w  = $signed({{(CMP_W - nrsi_pkg::EXT_W){1'b0}}, r_reg.in_extent});
        lim   = (in_w > CAP) ? CAP : in_w;
        hi    = lim - CMP_W'(1);
        cl0   = (idx_w > hi) ? hi : idx_w;
        cl1   = cl0[CMP_W-1] ? '0 : cl0;
        cl2   = (cl1 > FIELD_MAX) ? FIELD_MAX : cl1;
        if (idx_w > SRC_HI)
            src_w = SRC_HI;
        else if (idx_w < SRC_LO)
            src_w = SRC_LO;
        else
            src_w = idx_w;
        if (r_reg.zero)
        begin
            o_next.src_index     = '0;
            o_next.clamped_index = '0;
        end
        else
        begin
            o_next.src_index     = src_w[nrsi_pkg::SRC_W-1:0];
            o_next.clamped_index = cl2[nrsi_pkg::CLAMP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_r)
                r_valid_reg <= in_valid;
            if (en_o)
                o_valid_reg <= r_valid_reg;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en_r)
            r_reg <= r_next;
        if (en_o)
            o_reg <= o_next;
    end

    assign out_valid = o_valid_reg;
    assign out_item  = o_reg;

endmodule

@@ hdl/nearest_resize_source_index_top.sv @@
// Nearest-resize source index generator along one axis.
// Request items carry an output position with the output and input extents;
// each yields one response item: the rounded source index and that index
// clamped into the input axis.
// Channels: req_valid/req_ready/req_item in, rsp_valid/rsp_ready/rsp_item out,
// both valid/ready, an item moving when valid and ready are high together.
// Configuration: APB-style port, coord_mode at 0x0, rounding_mode at 0x4;
// write only while no item is in flight. pready is tied high.
// Pipeline: 3 front-end stages, 8 divider stages and 2 rounding and clamp
// stages. Throughput: one item per clock while rsp_ready is high; the
// divider resolves two quotient bits per stage and sets the depth.
// Reset clears both mode registers to zero and empties the pipeline.
// When rsp_ready is low the response holds and the stages behind it keep
// filling bubbles; req_ready falls only once every stage holds an item.
// Depends on nrsi_pkg, nrsi_front, nrsi_div and nrsi_back.
module nearest_resize_source_index_top #(
    parameter int MAX_EXTENT = nrsi_pkg::MAX_EXTENT_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nrsi_pkg::ADDR_W-1:0]   paddr,
    input  logic [nrsi_pkg::DATA_W-1:0]   pwdata,
    output logic [nrsi_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  nrsi_pkg::req_item_t           req_item,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output nrsi_pkg::rsp_item_t           rsp_item
);

    nrsi_pkg::coord_mode_t coord_mode_reg, coord_mode_next;
    nrsi_pkg::round_mode_t rounding_mode_reg, rounding_mode_next;
    nrsi_pkg::reg_index_t  reg_index;
    logic                  cfg_write;

    logic                  front_valid, front_ready;
    nrsi_pkg::front_item_t front_item;
    logic                  div_valid, div_ready;
    nrsi_pkg::div_stage_t  div_item;

    // Decode the register slot and the write strobe
    assign pready    = 1'b1;
    assign reg_index = nrsi_pkg::reg_index_t'(paddr[nrsi_pkg::ADDR_W-1]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        coord_mode_next    = coord_mode_reg;
        rounding_mode_next = rounding_mode_reg;
        if (cfg_write)
        begin
            case (reg_index)
                nrsi_pkg::REG_COORD_MODE:
                    coord_mode_next = nrsi_pkg::coord_mode_t'(pwdata[1:0]);
                nrsi_pkg::REG_ROUNDING_MODE:
                    rounding_mode_next = nrsi_pkg::round_mode_t'(pwdata[1:0]);
                default:
                    coord_mode_next = coord_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_mode_reg    <= nrsi_pkg::COORD_CENTRED;
            rounding_mode_reg <= nrsi_pkg::ROUND_TIE_DOWN;
        end
        else
        begin
            coord_mode_reg    <= coord_mode_next;
            rounding_mode_reg <= rounding_mode_next;
        end
    end

    // Read back the selected register
    always_comb
    begin
        case (reg_index)
            nrsi_pkg::REG_COORD_MODE:
                prdata = {{(nrsi_pkg::DATA_W - 2){1'b0}}, coord_mode_reg};
            nrsi_pkg::REG_ROUNDING_MODE:
                prdata = {{(nrsi_pkg::DATA_W - 2){1'b0}}, rounding_mode_reg};
            default:
                prdata = '0;
        endcase
    end

    nrsi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coord_mode (coord_mode_reg),
        .in_valid   (req_valid),
        .in_ready   (req_ready),
        .in_item    (req_item),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_item   (front_item)
    );

    nrsi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    nrsi_back #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rounding_mode (rounding_mode_reg),
        .in_valid      (div_valid),
        .in_ready      (div_ready),
        .in_item       (div_item),
        .out_valid     (rsp_valid),
        .out_ready     (rsp_ready),
        .out_item      (rsp_item)
    );

endmodule

@@ tb/nearest_resize_source_index_top_tb.sv @@
// Testbench for nearest_resize_source_index_top: directed corner items, then random
// items under four idling phases, each response checked against an in-bench predictor.
// Depends on nrsi_pkg and the RTL under hdl.
module nearest_resize_source_index_top_tb;

    localparam int SETTLE_CYCLES = 20;
    localparam int CHUNK_ITEMS   = 24;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [nrsi_pkg::ADDR_W-1:0] paddr = '0;
    logic [nrsi_pkg::DATA_W-1:0] pwdata = '0;
    logic [nrsi_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        req_valid = 1'b0;
    logic                        req_ready;
    nrsi_pkg::req_item_t         req_item = '0;
    logic                        rsp_valid;
    logic                        rsp_ready = 1'b0;
    nrsi_pkg::rsp_item_t         rsp_item;

    // Shadow of the mode registers as last written
    nrsi_pkg::coord_mode_t coord_shadow = nrsi_pkg::COORD_CENTRED;
    nrsi_pkg::round_mode_t round_shadow = nrsi_pkg::ROUND_TIE_DOWN;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int fail_count = 0;

    nrsi_pkg::rsp_item_t pending_index_q[$];

    nearest_resize_source_index_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exact source index: floor the fraction num/den, round by mode, then saturate and clamp
    function automatic nrsi_pkg::rsp_item_t predict_source_index(nrsi_pkg::req_item_t it,
                                                                 nrsi_pkg::coord_mode_t cm,
                                                                 nrsi_pkg::round_mode_t rm);
        longint              pos;
        longint              n_out;
        longint              n_in;
        longint              num;
        longint              den;
        longint              q;
        longint              r;
        longint              idx;
        longint              src;
        longint              hi;
        longint              cl;
        nrsi_pkg::rsp_item_t res;
        pos   = it.out_pos;
        n_out = it.out_extent;
        n_in  = it.in_extent;
        idx   = 0;
        case (cm)
            nrsi_pkg::COORD_CORNER_FIT:
            begin
                num = pos * (n_in - 1);
                den = n_out - 1;
            end
            nrsi_pkg::COORD_ASYMMETRIC:
            begin
                num = pos * n_in;
                den = n_out;
            end
            default:
            begin
                num = (2 * pos + 1) * n_in - n_out;
                den = 2 * n_out;
            end
        endcase
        // Empty input, zero denominator and single-pixel output under the zeroing rule
        if (n_in > 0 && den > 0 && !(cm == nrsi_pkg::COORD_CENTRED_NZ && n_out <= 1))
        begin
            q = num / den;
            r = num % den;
            if (r < 0)
            begin
                q = q - 1;
                r = r + den;
            end
            case (rm)
                nrsi_pkg::ROUND_TIE_UP: idx = (2 * r >= den) ? q + 1 : q;
                nrsi_pkg::ROUND_FLOOR:  idx = q;
                nrsi_pkg::ROUND_CEIL:   idx = (r > 0) ? q + 1 : q;
                default:                idx = (2 * r > den) ? q + 1 : q;
            endcase
        end
        src = idx;
        if (src < -8192)
            src = -8192;
        if (src > 8191)
            src = 8191;
        if (n_in <= 0)
            cl = 0;
        else
        begin
            hi = ((n_in > nrsi_pkg::MAX_EXTENT_DEFAULT) ? nrsi_pkg::MAX_EXTENT_DEFAULT
                                                        : n_in) - 1;
            cl = idx;
            if (cl > hi)
                cl = hi;
            if (cl < 0)
                cl = 0;
            if (cl > 4095)
                cl = 4095;
        end
        res.src_index     = src[nrsi_pkg::SRC_W-1:0];
        res.clamped_index = cl[nrsi_pkg::CLAMP_W-1:0];
        return res;
    endfunction

    // Receiver: drop ready at random according to the current phase
    always @(posedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

    // Compare each accepted response with the oldest prediction
    always @(posedge clk)
    begin
        nrsi_pkg::rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_index_q.size() == 0)
            begin
                $display("%0t: unexpected response src_index %0d clamped_index %0d",
                         $time, rsp_item.src_index, rsp_item.clamped_index);
                fail_count++;
            end
            else
            begin
                want = pending_index_q.pop_front();
                if (rsp_item.src_index !== want.src_index)
                begin
                    $display("%0t: src_index expected %0d got %0d",
                             $time, want.src_index, rsp_item.src_index);
                    fail_count++;
                end
                if (rsp_item.clamped_index !== want.clamped_index)
                begin
                    $display("%0t: clamped_index expected %0d got %0d",
                             $time, want.clamped_index, rsp_item.clamped_index);
                    fail_count++;
                end
            end
        end
    end

    // Offer one item, idling first at random; return at the edge that accepts it
    task automatic send_req(input nrsi_pkg::req_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_index_q.push_back(predict_source_index(it, coord_shadow, round_shadow));
    endtask

    // Hold off the sender until every response is back and the pipeline is empty
    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_index_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge
    task automatic reg_write(input nrsi_pkg::reg_index_t idx,
                             input logic [nrsi_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= nrsi_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_modes(input nrsi_pkg::coord_mode_t cm, input nrsi_pkg::round_mode_t rm);
        wait_idle();
        reg_write(nrsi_pkg::REG_COORD_MODE, nrsi_pkg::DATA_W'(cm));
        reg_write(nrsi_pkg::REG_ROUNDING_MODE, nrsi_pkg::DATA_W'(rm));
        coord_shadow = cm;
        round_shadow = rm;
    endtask

    function automatic nrsi_pkg::req_item_t make_req(int pos, int n_out, int n_in);
        nrsi_pkg::req_item_t it;
        it.out_pos    = pos[nrsi_pkg::POS_W-1:0];
        it.out_extent = n_out[nrsi_pkg::EXT_W-1:0];
        it.in_extent  = n_in[nrsi_pkg::EXT_W-1:0];
        return it;
    endfunction

    // Mostly well-formed positions within the output axis, some scale ratios, some noise
    function automatic nrsi_pkg::req_item_t random_req();
        int kind;
        int n_in;
        int n_out;
        int mult;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            n_in  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
            n_out = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
            return make_req($urandom_range(0, n_out - 1), n_out, n_in);
        end
        else if (kind < 80)
        begin
            // Integer scale factors produce exact halves, so rounding ties
            n_in = $urandom_range(1, 64);
            mult = $urandom_range(1, 8);
            if ($urandom_range(0, 1) == 1)
            begin
                n_out = n_in * mult;
            end
            else
            begin
                n_out = n_in;
                n_in  = n_in * mult;
            end
            return make_req($urandom_range(0, n_out - 1), n_out, n_in);
        end
        else if (kind < 90)
            return make_req($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 3));
        else
            return make_req($urandom_range(0, 4095), $urandom_range(0, 8191),
                            $urandom_range(0, 8191));
    endfunction

    // Change modes only when the item needs different ones
    task automatic run_case(input nrsi_pkg::coord_mode_t cm, input nrsi_pkg::round_mode_t rm,
                            input int pos, input int n_out, input int n_in);
        if (cm != coord_shadow || rm != round_shadow)
            set_modes(cm, rm);
        send_req(make_req(pos, n_out, n_in));
    endtask

    // Reset values of both registers, with no write yet
    task automatic test_reset_defaults();
        send_req(make_req(0, 2, 4));
        send_req(make_req(3, 8, 3));
        send_req(make_req(1, 3, 8));
    endtask

    task automatic test_special_cases();
        // Empty input, all fields at their maximum, negative coordinate
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_TIE_DOWN, 0, 0, 0);
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_TIE_DOWN, 4095, 8191, 8191);
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_TIE_DOWN, 0, 8191, 1);
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_TIE_DOWN, 0, 2, 4);
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_TIE_DOWN, 0, 1, 100);
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_TIE_DOWN, 0, 8191, 8191);
        // Exact half: the two nearest modes part here
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_TIE_UP, 0, 2, 4);
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_FLOOR, 1, 3, 8191);
        run_case(nrsi_pkg::COORD_CENTRED, nrsi_pkg::ROUND_CEIL, 1, 3, 8191);
        // Zero and negative denominators under the corner-fit rule, then saturation
        run_case(nrsi_pkg::COORD_CORNER_FIT, nrsi_pkg::ROUND_TIE_DOWN, 5, 1, 100);
        run_case(nrsi_pkg::COORD_CORNER_FIT, nrsi_pkg::ROUND_TIE_UP, 5, 0, 100);
        run_case(nrsi_pkg::COORD_CORNER_FIT, nrsi_pkg::ROUND_CEIL, 4095, 2, 8191);
        run_case(nrsi_pkg::COORD_CORNER_FIT, nrsi_pkg::ROUND_FLOOR, 4095, 4096, 4096);
        // Asymmetric: zero extent, position beyond the axis, input above the maximum
        run_case(nrsi_pkg::COORD_ASYMMETRIC, nrsi_pkg::ROUND_FLOOR, 3, 0, 10);
        run_case(nrsi_pkg::COORD_ASYMMETRIC, nrsi_pkg::ROUND_FLOOR, 100, 10, 20);
        run_case(nrsi_pkg::COORD_ASYMMETRIC, nrsi_pkg::ROUND_FLOOR, 1, 1, 8191);
        run_case(nrsi_pkg::COORD_ASYMMETRIC, nrsi_pkg::ROUND_FLOOR, 1, 2, 8000);
        run_case(nrsi_pkg::COORD_ASYMMETRIC, nrsi_pkg::ROUND_CEIL, 4095, 1, 8191);
        run_case(nrsi_pkg::COORD_ASYMMETRIC, nrsi_pkg::ROUND_CEIL, 4095, 8191, 1);
        run_case(nrsi_pkg::COORD_ASYMMETRIC, nrsi_pkg::ROUND_TIE_UP, 4095, 4096, 4096);
        // Single-pixel output under the zeroing centred rule against a normal one
        run_case(nrsi_pkg::COORD_CENTRED_NZ, nrsi_pkg::ROUND_TIE_DOWN, 0, 1, 100);
        run_case(nrsi_pkg::COORD_CENTRED_NZ, nrsi_pkg::ROUND_TIE_UP, 7, 0, 100);
        run_case(nrsi_pkg::COORD_CENTRED_NZ, nrsi_pkg::ROUND_TIE_UP, 0, 2, 4);
    endtask

    // Pause the sender until the pipeline has fully drained, then resume
    task automatic test_drain_pause();
        rsp_stall_pct = 61;
        repeat (10) send_req(random_req());
        wait_idle();
        repeat (10) send_req(random_req());
        rsp_stall_pct = 0;
    endtask

    task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % CHUNK_ITEMS == 0)
                set_modes(nrsi_pkg::coord_mode_t'($urandom_range(0, 3)),
                          nrsi_pkg::round_mode_t'($urandom_range(0, 3)));
            send_req(random_req());
        end
        send_idle_pct = 0;
        rsp_stall_pct = 0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_special_cases();
        test_drain_pause();
        test_random_phase(120, 0, 0);
        test_random_phase(120, 61, 0);
        test_random_phase(120, 0, 61);
        test_random_phase(120, 11, 11);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ nearest_resize_source_index_top.f @@
hdl/nrsi_pkg.sv
hdl/nrsi_front.sv
hdl/nrsi_div.sv
hdl/nrsi_back.sv
hdl/nearest_resize_source_index_top.sv
tb/nearest_resize_source_index_top_tb.sv
